// ===== hw/rtl/bc3d_pkg.sv =====
package bc3d_pkg;

  localparam int unsigned DimW      = 13;
  localparam int unsigned BlkPosW   = 10;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned AlphaNumW = 11;
  localparam int unsigned ColNumW   = 10;

  localparam logic [CfgIndexW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_FORCE_FOUR   = 2'd2;

  localparam logic [DimW-1:0] RESET_WIDTH  = 13'd256;
  localparam logic [DimW-1:0] RESET_HEIGHT = 13'd256;

  localparam logic [3:0] PIX_LAST = 4'd15;

  // Reciprocal constants: floor(x * M >> S) equals floor(x / d) over the
  // numerator range that each divisor sees here.
  localparam logic [11:0] RECIP_3 = 12'd683;
  localparam logic [11:0] RECIP_5 = 12'd3277;
  localparam logic [11:0] RECIP_7 = 12'd2341;

  typedef enum logic [2:0] {
    DIV_1,
    DIV_2,
    DIV_3,
    DIV_5,
    DIV_7
  } div_e;

  // One queued block, already classified by the front end.
  typedef struct packed {
    logic [63:0]         alpha_word;
    logic [63:0]         colour_word;
    logic                four_colour;
    logic                dim_error;
    logic                frame_last;
    logic [BlkPosW-1:0]  block_col;
    logic [BlkPosW-1:0]  block_row;
  } entry_t;

  // One pixel between the numerator stage and the divide stage.
  typedef struct packed {
    logic [AlphaNumW-1:0]          alpha_num;
    div_e                          alpha_div;
    logic [2:0][ColNumW-1:0]       col_num;
    div_e                          col_div;
    logic [CoordW-1:0]             pixel_x;
    logic [CoordW-1:0]             pixel_y;
    logic                          block_end;
    logic                          frame_end;
    logic                          dim_error;
  } stage_t;

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        opacity;
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic              block_end;
    logic              frame_end;
    logic              dim_error;
  } pix_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    expand5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    expand6 = {v, v[5:4]};
  endfunction

  function automatic logic [7:0] div_const(input logic [AlphaNumW-1:0] num,
                                           input div_e div);
    logic [22:0] prod;
    prod = 23'd0;
    div_const = 8'd0;
    unique case (div)
      DIV_1: div_const = num[7:0];
      DIV_2: div_const = num[8:1];
      DIV_3: begin
        prod = 23'(num) * 23'(RECIP_3);
        div_const = prod[18:11];
      end
      DIV_5: begin
        prod = 23'(num) * 23'(RECIP_5);
        div_const = prod[21:14];
      end
      DIV_7: begin
        prod = 23'(num) * 23'(RECIP_7);
        div_const = prod[21:14];
      end
      default: div_const = 8'd0;
    endcase
  endfunction

endpackage

// ===== hw/rtl/bc3d_front.sv =====
module bc3d_front #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bc3d_pkg::CfgIndexW-1:0]        cfg_index_i,
  input  logic [bc3d_pkg::DimW-1:0]             cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [63:0]                           alpha_word_i,
  input  logic [63:0]                           colour_word_i,
  output logic                                  push_o,
  output bc3d_pkg::entry_t                      entry_o,
  input  logic                                  full_i
);

  logic [bc3d_pkg::DimW-1:0]    width_q, width_d;
  logic [bc3d_pkg::DimW-1:0]    height_q, height_d;
  logic                         force_q, force_d;
  logic [bc3d_pkg::BlkPosW-1:0] col_q, col_d;
  logic [bc3d_pkg::BlkPosW-1:0] row_q, row_d;

  logic                         dims_ok;
  logic [bc3d_pkg::DimW-3:0]    blk_cols, blk_rows;
  logic                         last_col, last_row;
  logic                         accept;

  function automatic logic dim_valid(input logic [bc3d_pkg::DimW-1:0] d);
    dim_valid = (d != '0) && (d[1:0] == 2'b00) && (32'(d) <= 32'(MAX_DIMENSION));
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign accept      = in_valid_i && !full_i;
  assign push_o      = accept;

  assign dims_ok  = dim_valid(width_q) && dim_valid(height_q);
  assign blk_cols = width_q[bc3d_pkg::DimW-1:2];
  assign blk_rows = height_q[bc3d_pkg::DimW-1:2];
  assign last_col = ({1'b0, col_q} + 11'd1) >= blk_cols;
  assign last_row = ({1'b0, row_q} + 11'd1) >= blk_rows;

  always_comb begin
    entry_o.alpha_word  = alpha_word_i;
    entry_o.colour_word = colour_word_i;
    entry_o.four_colour = force_q || (colour_word_i[15:0] > colour_word_i[31:16]);
    entry_o.dim_error   = !dims_ok;
    entry_o.frame_last  = last_col && last_row;
    entry_o.block_col   = col_q;
    entry_o.block_row   = row_q;
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    force_d  = force_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bc3d_pkg::CFG_IMAGE_WIDTH:  width_d  = cfg_data_i;
        bc3d_pkg::CFG_IMAGE_HEIGHT: height_d = cfg_data_i;
        bc3d_pkg::CFG_FORCE_FOUR:   force_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The block position advances only for blocks that actually decode.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept && dims_ok) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 10'd1;
      end else begin
        col_d = col_q + 10'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bc3d_pkg::RESET_WIDTH;
      height_q <= bc3d_pkg::RESET_HEIGHT;
      force_q  <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      force_q  <= force_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

// ===== hw/rtl/bc3d_fifo.sv =====
module bc3d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/bc3d_back.sv =====
module bc3d_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  bc3d_pkg::entry_t  entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bc3d_pkg::pix_t    pix_o
);

  logic [3:0]             pix_q, pix_d;
  logic                   a_valid_q, a_valid_d;
  bc3d_pkg::stage_t       a_q, a_d, a_calc;
  logic                   out_valid_q, out_valid_d;
  bc3d_pkg::pix_t         out_q, out_d;
  logic                   out_free, a_ready, issue, entry_done;

  logic [2:0]             ai;
  logic [1:0]             ci;
  logic [7:0]             a0, a1;
  logic [3:0]             w0, w1;
  logic [11:0]            alpha_sum;
  logic [2:0][7:0]        e0, e1;
  logic                   last_pix;

  assign out_free   = !out_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || out_free;
  assign issue      = valid_i && a_ready;
  assign last_pix   = (pix_q == bc3d_pkg::PIX_LAST);
  assign entry_done = last_pix || entry_i.dim_error;
  assign pop_o      = issue && entry_done;

  assign ai = entry_i.alpha_word[16 + 3 * pix_q +: 3];
  assign ci = entry_i.colour_word[32 + 2 * pix_q +: 2];
  assign a0 = entry_i.alpha_word[7:0];
  assign a1 = entry_i.alpha_word[15:8];

  // Interpolation weights of the alpha palette: (8-i, i-1) over seven steps
  // when a0 > a1, (6-i, i-1) over five steps otherwise.
  assign w0 = (a0 > a1) ? 4'd8 - 4'(ai) : 4'd6 - 4'(ai);
  assign w1 = 4'(ai) - 4'd1;
  assign alpha_sum = 12'(w0) * 12'(a0) + 12'(w1) * 12'(a1);

  always_comb begin
    e0[0] = bc3d_pkg::expand5(entry_i.colour_word[15:11]);
    e0[1] = bc3d_pkg::expand6(entry_i.colour_word[10:5]);
    e0[2] = bc3d_pkg::expand5(entry_i.colour_word[4:0]);
    e1[0] = bc3d_pkg::expand5(entry_i.colour_word[31:27]);
    e1[1] = bc3d_pkg::expand6(entry_i.colour_word[26:21]);
    e1[2] = bc3d_pkg::expand5(entry_i.colour_word[20:16]);
  end

  always_comb begin
    a_calc = '0;
    a_calc.alpha_div = bc3d_pkg::DIV_1;
    a_calc.col_div   = bc3d_pkg::DIV_1;
    if (entry_i.dim_error) begin
      a_calc.block_end = 1'b1;
      a_calc.dim_error = 1'b1;
    end else begin
      if (ai == 3'd0) begin
        a_calc.alpha_num = 11'(a0);
      end else if (ai == 3'd1) begin
        a_calc.alpha_num = 11'(a1);
      end else if (a0 > a1) begin
        a_calc.alpha_num = alpha_sum[10:0];
        a_calc.alpha_div = bc3d_pkg::DIV_7;
      end else if (ai == 3'd6) begin
        a_calc.alpha_num = '0;
      end else if (ai == 3'd7) begin
        a_calc.alpha_num = 11'd255;
      end else begin
        a_calc.alpha_num = alpha_sum[10:0];
        a_calc.alpha_div = bc3d_pkg::DIV_5;
      end

      for (int k = 0; k < 3; k++) begin
        unique case (ci)
          2'd0: a_calc.col_num[k] = 10'(e0[k]);
          2'd1: a_calc.col_num[k] = 10'(e1[k]);
          2'd2: begin
            if (entry_i.four_colour) begin
              a_calc.col_num[k] = {1'b0, e0[k], 1'b0} + 10'(e1[k]);
            end else begin
              a_calc.col_num[k] = 10'(e0[k]) + 10'(e1[k]);
            end
          end
          2'd3: begin
            if (entry_i.four_colour) begin
              a_calc.col_num[k] = 10'(e0[k]) + {1'b0, e1[k], 1'b0};
            end else begin
              a_calc.col_num[k] = '0;
            end
          end
          default: a_calc.col_num[k] = '0;
        endcase
      end
      if (ci == 2'd2) begin
        a_calc.col_div = entry_i.four_colour ? bc3d_pkg::DIV_3 : bc3d_pkg::DIV_2;
      end else if (ci == 2'd3 && entry_i.four_colour) begin
        a_calc.col_div = bc3d_pkg::DIV_3;
      end

      a_calc.pixel_x   = {entry_i.block_col, pix_q[1:0]};
      a_calc.pixel_y   = {entry_i.block_row, pix_q[3:2]};
      a_calc.block_end = last_pix;
      a_calc.frame_end = last_pix && entry_i.frame_last;
    end
  end

  always_comb begin
    pix_d     = pix_q;
    a_valid_d = a_valid_q;
    a_d       = a_q;
    if (issue) begin
      a_valid_d = 1'b1;
      a_d       = a_calc;
      pix_d     = entry_done ? '0 : pix_q + 4'd1;
    end else if (out_free) begin
      a_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d   = a_valid_q;
      out_d.red     = bc3d_pkg::div_const(11'(a_q.col_num[0]), a_q.col_div);
      out_d.green   = bc3d_pkg::div_const(11'(a_q.col_num[1]), a_q.col_div);
      out_d.blue    = bc3d_pkg::div_const(11'(a_q.col_num[2]), a_q.col_div);
      out_d.opacity = bc3d_pkg::div_const(a_q.alpha_num, a_q.alpha_div);
      out_d.pixel_x   = a_q.pixel_x;
      out_d.pixel_y   = a_q.pixel_y;
      out_d.block_end = a_q.block_end;
      out_d.frame_end = a_q.frame_end;
      out_d.dim_error = a_q.dim_error;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q       <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pix_q       <= pix_d;
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign pix_o       = out_q;

endmodule

// ===== hw/rtl/bc3_texture_block_decoder.sv =====
// BC3 (DXT5) texture block decoder.
// Input stream: one 16-byte block per word, in raster block order.
// s_axis_tdata carries the alpha half in bits 63:0 and the colour half in
// bits 127:64. Output stream: one RGBA8 pixel per word with its image
// coordinates; tlast marks the last word of a block.
// The configuration channel writes image width (index 0), image height
// (index 1) and the force-four-colour flag (index 2); it is always ready.
// If the configured size is invalid, each block yields a single word with
// the dimension error flag set and the block position unchanged.
// The back-end pixel sequencer sends one pixel per cycle while the receiver
// is ready; an error block yields its single word. From the accept of a
// block to its first pixel it passes the queue, the numerator stage and
// the divide into the output register.
// The front end keeps accepting blocks while the queue has room, so a stall
// of the receiver holds the output register and backs up into the queue.
// Reset restores width and height to 256, clears the force flag and returns
// the block position to the top left corner; the queue and pipeline empty.
module bc3_texture_block_decoder #(
  parameter int unsigned MAX_DIMENSION = 4096,
  parameter int unsigned QUEUE_DEPTH   = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bc3d_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [bc3d_pkg::DimW-1:0]         cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // alpha_word [63:0], colour_word [127:64]
  input  logic [127:0]                      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // red [7:0], green [15:8], blue [23:16], opacity [31:24],
  // pixel_x [43:32], pixel_y [55:44]
  output logic [55:0]                       m_axis_tdata,
  output logic                              m_axis_tlast,
  // frame_end [0], dimension_error [1]
  output logic [1:0]                        m_axis_tuser
);

  logic              push, full, q_valid, pop;
  bc3d_pkg::entry_t  push_entry, head_entry;
  bc3d_pkg::pix_t    pix;

  bc3d_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .alpha_word_i  (s_axis_tdata[63:0]),
    .colour_word_i (s_axis_tdata[127:64]),
    .push_o        (push),
    .entry_o       (push_entry),
    .full_i        (full)
  );

  bc3d_fifo #(
    .WIDTH($bits(bc3d_pkg::entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (head_entry)
  );

  bc3d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pix_o       (pix)
  );

  assign m_axis_tdata = {pix.pixel_y, pix.pixel_x, pix.opacity, pix.blue, pix.green, pix.red};
  assign m_axis_tlast = pix.block_end;
  assign m_axis_tuser = {pix.dim_error, pix.frame_end};

endmodule

// ===== bench/tb.sv =====
module tb;

  localparam int unsigned CfgIndexW = bc3d_pkg::CfgIndexW;
  localparam int unsigned DimW = bc3d_pkg::DimW;
  localparam int unsigned BlkPosW = bc3d_pkg::BlkPosW;
  localparam int MaxDim = 4096;
  localparam int IdleLimit = 2000;
  localparam int DrainTail = 8;
  localparam int RandomBlocks = 250;
  localparam logic [CfgIndexW-1:0] CFG_SPARE = 2'd3;

  // Alpha index i%8 and colour index i%4 for pixel i, plus the reversed ramps.
  localparam logic [47:0] ALPHA_RAMP = 48'o7654321076543210;
  localparam logic [47:0] ALPHA_DOWN = 48'o0123456701234567;
  localparam logic [31:0] COLOUR_RAMP = 32'hE4E4E4E4;
  localparam logic [31:0] COLOUR_DOWN = 32'h1B1B1B1B;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  opacity;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        block_end;
    logic        frame_end;
    logic        dim_err;
  } rgba_pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [DimW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic m_axis_tlast;
  logic [1:0] m_axis_tuser;

  bc3_texture_block_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the decoder's registers and block position.
  logic [DimW-1:0] img_w = bc3d_pkg::RESET_WIDTH;
  logic [DimW-1:0] img_h = bc3d_pkg::RESET_HEIGHT;
  logic force_four = 1'b0;
  logic [BlkPosW-1:0] next_col = '0;
  logic [BlkPosW-1:0] next_row = '0;

  logic [127:0] block_queue[$];
  rgba_pixel_t expected_pixels[$];
  rgba_pixel_t seen_pixel;
  rgba_pixel_t want_pixel;
  int fail_count = 0;
  int src_gap = 0;
  int sink_stall = 0;
  int idle_cycles = 0;
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DimW-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return DimW'(4 * $urandom_range(1, 1000) + $urandom_range(1, 3));
    if (r < 8) return DimW'($urandom_range(MaxDim + 1, 8191));
    if (r < 12) return DimW'(MaxDim);
    if (r < 16) return DimW'(4);
    return DimW'(4 * $urandom_range(1, 8));
  endfunction

  function automatic logic [127:0] pack_block(input logic [7:0] a0, input logic [7:0] a1,
                                              input logic [47:0] aidx,
                                              input logic [15:0] c0, input logic [15:0] c1,
                                              input logic [31:0] cidx);
    return {cidx, c1, c0, aidx, a1, a0};
  endfunction

  function automatic logic [127:0] random_block();
    logic [7:0] a0;
    logic [7:0] a1;
    logic [15:0] c0;
    logic [15:0] c1;
    int r;
    a0 = 8'($urandom());
    a1 = 8'($urandom());
    c0 = 16'($urandom());
    c1 = 16'($urandom());
    r = $urandom_range(0, 9);
    if (r == 0) a1 = a0;
    else if (r == 1) begin
      a0 = 8'hFF;
      a1 = 8'h00;
    end else if (r == 2) begin
      a0 = 8'h00;
      a1 = 8'hFF;
    end
    r = $urandom_range(0, 9);
    if (r == 0) c1 = c0;
    else if (r == 1) begin
      c0 = 16'hFFFF;
      c1 = 16'h0000;
    end else if (r == 2) begin
      c0 = 16'h0000;
      c1 = 16'hFFFF;
    end
    return pack_block(a0, a1, {16'($urandom()), 32'($urandom())}, c0, c1, 32'($urandom()));
  endfunction

  function automatic bit dim_ok(input logic [DimW-1:0] d);
    return d != '0 && d[1:0] == 2'b00 && int'(d) <= MaxDim;
  endfunction

  // RGB565 to 8 bits per channel by replicating the top bits; red in the low byte.
  function automatic logic [23:0] widen565(input logic [15:0] c);
    return {c[4:0], c[4:2], c[10:5], c[10:9], c[15:11], c[15:13]};
  endfunction

  // Works out the sixteen pixels of one accepted block, or the single error
  // word; a decoded block also advances the block position.
  task automatic decode_block(input logic [127:0] blk);
    logic [63:0] aw;
    logic [63:0] cw;
    logic [23:0] w0;
    logic [23:0] w1;
    int a0, a1, e0, e1, ai, ci;
    int alpha_pal[8];
    int col_pal[12];
    bit four, last_col, last_row;
    rgba_pixel_t px;
    aw = blk[63:0];
    cw = blk[127:64];
    px = '0;
    if (!dim_ok(img_w) || !dim_ok(img_h)) begin
      px.block_end = 1'b1;
      px.dim_err = 1'b1;
      expected_pixels.push_back(px);
      return;
    end
    a0 = int'(aw[7:0]);
    a1 = int'(aw[15:8]);
    alpha_pal[0] = a0;
    alpha_pal[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) alpha_pal[1 + k] = ((7 - k) * a0 + k * a1) / 7;
    end else begin
      for (int k = 1; k <= 4; k++) alpha_pal[1 + k] = ((5 - k) * a0 + k * a1) / 5;
      alpha_pal[6] = 0;
      alpha_pal[7] = 255;
    end
    w0 = widen565(cw[15:0]);
    w1 = widen565(cw[31:16]);
    four = force_four || (cw[15:0] > cw[31:16]);
    for (int k = 0; k < 3; k++) begin
      e0 = int'(w0[8*k +: 8]);
      e1 = int'(w1[8*k +: 8]);
      col_pal[k] = e0;
      col_pal[3 + k] = e1;
      if (four) begin
        col_pal[6 + k] = (2 * e0 + e1) / 3;
        col_pal[9 + k] = (e0 + 2 * e1) / 3;
      end else begin
        col_pal[6 + k] = (e0 + e1) / 2;
        col_pal[9 + k] = 0;
      end
    end
    // A position left past the edge by a smaller size counts as the last one.
    last_col = int'(next_col) + 1 >= (int'(img_w) >> 2);
    last_row = int'(next_row) + 1 >= (int'(img_h) >> 2);
    for (int i = 0; i < 16; i++) begin
      ai = int'((aw >> (16 + 3 * i)) & 64'h7);
      ci = int'((cw >> (32 + 2 * i)) & 64'h3);
      px.red = 8'(col_pal[3 * ci]);
      px.green = 8'(col_pal[3 * ci + 1]);
      px.blue = 8'(col_pal[3 * ci + 2]);
      px.opacity = 8'(alpha_pal[ai]);
      px.pixel_x = 12'(int'(next_col) * 4 + (i % 4));
      px.pixel_y = 12'(int'(next_row) * 4 + (i / 4));
      px.block_end = (i == 15);
      px.frame_end = (i == 15) && last_col && last_row;
      px.dim_err = 1'b0;
      expected_pixels.push_back(px);
    end
    if (last_col) begin
      next_col = '0;
      if (last_row) next_row = '0;
      else next_row = next_row + BlkPosW'(1);
    end else begin
      next_col = next_col + BlkPosW'(1);
    end
  endtask

  // Block sender.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_block(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (block_queue.size() > 0) begin
          s_axis_tdata <= block_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          src_gap = src_steady ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Pixel receiver and checker.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_pixel.red = m_axis_tdata[7:0];
        seen_pixel.green = m_axis_tdata[15:8];
        seen_pixel.blue = m_axis_tdata[23:16];
        seen_pixel.opacity = m_axis_tdata[31:24];
        seen_pixel.pixel_x = m_axis_tdata[43:32];
        seen_pixel.pixel_y = m_axis_tdata[55:44];
        seen_pixel.block_end = m_axis_tlast;
        seen_pixel.frame_end = m_axis_tuser[0];
        seen_pixel.dim_err = m_axis_tuser[1];
        if (expected_pixels.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("unexpected word: rgba %0d %0d %0d %0d at (%0d,%0d)",
                     seen_pixel.red, seen_pixel.green, seen_pixel.blue,
                     seen_pixel.opacity, seen_pixel.pixel_x, seen_pixel.pixel_y);
        end else begin
          want_pixel = expected_pixels.pop_front();
          if (seen_pixel !== want_pixel) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) begin
              $display("mismatch want: rgba %0d %0d %0d %0d at (%0d,%0d) last %0b frame %0b err %0b",
                       want_pixel.red, want_pixel.green, want_pixel.blue,
                       want_pixel.opacity, want_pixel.pixel_x, want_pixel.pixel_y,
                       want_pixel.block_end, want_pixel.frame_end, want_pixel.dim_err);
              $display("         got:  rgba %0d %0d %0d %0d at (%0d,%0d) last %0b frame %0b err %0b",
                       seen_pixel.red, seen_pixel.green, seen_pixel.blue,
                       seen_pixel.opacity, seen_pixel.pixel_x, seen_pixel.pixel_y,
                       seen_pixel.block_end, seen_pixel.frame_end, seen_pixel.dim_err);
            end
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall = sink_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 5) == 0) sink_stall = pick_gap();
      end
    end
  end

  // Ends a hung run: counts cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Waits until every queued block has been taken and every pixel has come back.
  task automatic drain();
    do @(posedge clk_i);
    while (block_queue.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0);
  endtask

  // Writes all three registers once the decoder is idle, optionally poking the
  // unused index as well, which the decoder must ignore.
  task automatic set_config(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                            input logic f, input bit poke_spare);
    logic [CfgIndexW-1:0] idx[4];
    logic [DimW-1:0] val[4];
    int cnt;
    idx[0] = bc3d_pkg::CFG_IMAGE_WIDTH;
    val[0] = w;
    idx[1] = bc3d_pkg::CFG_IMAGE_HEIGHT;
    val[1] = h;
    idx[2] = bc3d_pkg::CFG_FORCE_FOUR;
    val[2] = DimW'(f);
    idx[3] = CFG_SPARE;
    val[3] = DimW'($urandom());
    cnt = poke_spare ? 4 : 3;
    drain();
    for (int r = 0; r < cnt; r++) begin
      cfg_index_i <= idx[r];
      cfg_data_i <= val[r];
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i);
      while (!cfg_ready_o);
      case (idx[r])
        bc3d_pkg::CFG_IMAGE_WIDTH: img_w = val[r];
        bc3d_pkg::CFG_IMAGE_HEIGHT: img_h = val[r];
        bc3d_pkg::CFG_FORCE_FOUR: force_four = val[r][0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int issued;
    int n;
    int phase_no;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset size 256x256: both alpha modes, four- and three-colour order,
    // equal endpoints, all zeros and all ones.
    block_queue.push_back(pack_block(8'd255, 8'd0, ALPHA_RAMP, 16'hFFFF, 16'h0000, COLOUR_RAMP));
    block_queue.push_back(pack_block(8'd0, 8'd255, ALPHA_RAMP, 16'h0000, 16'hFFFF, COLOUR_RAMP));
    block_queue.push_back(pack_block(8'd128, 8'd128, ALPHA_RAMP, 16'h8410, 16'h8410,
                                     COLOUR_RAMP));
    block_queue.push_back('0);
    block_queue.push_back({128{1'b1}});
    block_queue.push_back(pack_block(8'd201, 8'd37, ALPHA_DOWN, 16'hF800, 16'h07E0, COLOUR_DOWN));
    block_queue.push_back(pack_block(8'd13, 8'd250, ALPHA_DOWN, 16'h001F, 16'hF81F, COLOUR_DOWN));

    // Largest size with the four-colour override on blocks that would be three-colour.
    set_config(13'd4096, 13'd4096, 1'b1, 1'b0);
    block_queue.push_back(pack_block(8'd90, 8'd91, ALPHA_RAMP, 16'h1234, 16'h5678, COLOUR_RAMP));
    block_queue.push_back(pack_block(8'd77, 8'd77, ALPHA_RAMP, 16'hABCD, 16'hABCD, COLOUR_RAMP));

    // Shrink the width under a column that lies past the new edge.
    set_config(13'd8, 13'd8, 1'b0, 1'b0);
    repeat (3) block_queue.push_back(random_block());

    // Walk down a tall narrow image, then shrink the height below the current row.
    set_config(13'd4, 13'd32, 1'b0, 1'b0);
    repeat (3) block_queue.push_back(random_block());
    set_config(13'd4, 13'd8, 1'b0, 1'b1);
    block_queue.push_back(random_block());

    // Zero, unaligned and oversize dimensions each give one error word.
    set_config(13'd0, 13'd8, 1'b0, 1'b0);
    block_queue.push_back(random_block());
    set_config(13'd6, 13'd8, 1'b0, 1'b0);
    block_queue.push_back(random_block());
    set_config(13'd4100, 13'd8, 1'b1, 1'b0);
    block_queue.push_back(random_block());
    set_config(13'd8, 13'd0, 1'b0, 1'b0);
    block_queue.push_back(random_block());
    set_config(13'd4, 13'd8188, 1'b0, 1'b0);
    block_queue.push_back(random_block());

    issued = 0;
    phase_no = 0;
    while (issued < RandomBlocks) begin
      set_config(pick_dim(), pick_dim(), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 7) == 0);
      src_steady = $urandom_range(0, 3) == 0;
      sink_steady = $urandom_range(0, 3) == 0;
      n = $urandom_range(8, 30);
      for (int i = 0; i < n; i++) begin
        // Now and then the sender holds off until the decoder has gone idle.
        if (i == n / 2 && phase_no % 3 == 0) begin
          drain();
          @(negedge clk_i);
        end
        block_queue.push_back(random_block());
      end
      issued = issued + n;
      phase_no = phase_no + 1;
    end

    drain();
    repeat (DrainTail) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bc3d_pkg.sv
hw/rtl/bc3d_front.sv
hw/rtl/bc3d_fifo.sv
hw/rtl/bc3d_back.sv
hw/rtl/bc3_texture_block_decoder.sv
bench/tb.sv
